/* rtl/drc_pkg.sv */
package drc_pkg;

    // Default table depth
    localparam int MAX_RANGES_DEF = 16;

    // Byte offsets and lengths
    localparam int OFS_W = 40;
    typedef logic [OFS_W-1:0] t_ofs;

    // One table entry: start in the upper half, exclusive end in the lower half
    localparam int ENTRY_W = 2 * OFS_W;

    // Request codes
    localparam logic [1:0] REQ_RECORD = 2'd0;
    localparam logic [1:0] REQ_DRAIN  = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_TRACKING  = 2'd0;
    localparam logic [1:0] CFG_MAP_START = 2'd1;
    localparam logic [1:0] CFG_MAP_END   = 2'd2;
    localparam logic [1:0] CFG_FLUSHABLE = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REC,
        ST_CLIP,
        ST_SEL,
        ST_SCAN,
        ST_MOVE,
        ST_APPEND,
        ST_DCHK,
        ST_DLOAD,
        ST_DOUT
    } t_state;

    // Table read address source
    typedef enum logic [1:0] {
        RSEL_ZERO,
        RSEL_NEXT,
        RSEL_LAST
    } t_rsel;

    // Table write address and data source
    typedef enum logic {
        WSEL_IDX,
        WSEL_CNT
    } t_wsel;

    // Operands of the shared subtractor
    typedef enum logic [1:0] {
        SUB_WINDOW,
        SUB_CLIP,
        SUB_ENTRY
    } t_subsel;

    typedef struct packed {
        logic    take_req;
        logic    do_clear;
        logic    set_seen;
        logic    ld_lo;
        logic    ld_clip;
        logic    ld_hi;
        logic    idx_zero;
        logic    idx_inc;
        logic    merge;
        logic    rd_en;
        t_rsel   rd_sel;
        logic    wr_en;
        t_wsel   wr_sel;
        logic    cnt_inc;
        logic    set_ovf;
        logic    out_fb;
        logic    out_rng;
        t_subsel sub_sel;
    } t_ctrl;

    typedef struct packed {
        logic       req_valid;
        logic [1:0] req_type;
        logic       tracking;
        logic       flushable;
        logic       seen;
        logic       ovf;
        logic       window_ok;
        logic       count_zero;
        logic       count_full;
        logic       clip_empty;
        logic       hit;
        logic       scan_more;
        logic       out_fire;
        logic       out_last;
    } t_stat;

endpackage

/* rtl/drc_ram.sv */
module drc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/drc_fsm.sv */
module drc_fsm import drc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_stat  i_stat,
    output t_state o_state,
    output t_ctrl  o_ctrl
);

    t_state r_state;
    t_state n_state;
    t_ctrl  ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_stat.req_valid) begin
                    if (i_stat.req_type == REQ_RECORD) begin
                        n_state = ST_REC;
                    end else if (i_stat.req_type == REQ_DRAIN) begin
                        n_state = ST_DCHK;
                    end
                end
            end
            ST_REC: begin
                if (!i_stat.tracking || i_stat.ovf || !i_stat.window_ok) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_CLIP;
                end
            end
            ST_CLIP: n_state = ST_SEL;
            ST_SEL: begin
                if (i_stat.clip_empty) begin
                    n_state = ST_IDLE;
                end else if (i_stat.count_zero) begin
                    n_state = ST_APPEND;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.hit) begin
                    n_state = i_stat.scan_more ? ST_MOVE : ST_APPEND;
                end else begin
                    n_state = i_stat.scan_more ? ST_SCAN : ST_APPEND;
                end
            end
            ST_MOVE:   n_state = ST_SCAN;
            ST_APPEND: n_state = ST_IDLE;
            ST_DCHK: begin
                if (!(i_stat.tracking && i_stat.flushable && i_stat.seen
                      && i_stat.window_ok)) begin
                    n_state = ST_IDLE;
                end else if (i_stat.ovf || i_stat.count_zero) begin
                    n_state = ST_DOUT;
                end else begin
                    n_state = ST_DLOAD;
                end
            end
            ST_DLOAD: n_state = ST_DOUT;
            ST_DOUT: begin
                if (i_stat.out_fire) begin
                    n_state = i_stat.out_last ? ST_IDLE : ST_DLOAD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        ctrl         = '0;
        ctrl.rd_sel  = RSEL_ZERO;
        ctrl.wr_sel  = WSEL_IDX;
        ctrl.sub_sel = SUB_WINDOW;
        unique case (r_state)
            ST_IDLE: begin
                ctrl.take_req = i_stat.req_valid;
                ctrl.do_clear = i_stat.req_valid && (i_stat.req_type == REQ_CLEAR);
            end
            ST_REC: begin
                ctrl.set_seen = i_stat.tracking;
                ctrl.ld_lo    = 1'b1;
            end
            ST_CLIP: begin
                ctrl.sub_sel = SUB_CLIP;
                ctrl.ld_clip = 1'b1;
            end
            ST_SEL: begin
                ctrl.ld_hi = 1'b1;
                if (!i_stat.clip_empty && !i_stat.count_zero) begin
                    ctrl.rd_en    = 1'b1;
                    ctrl.rd_sel   = RSEL_ZERO;
                    ctrl.idx_zero = 1'b1;
                end
            end
            ST_SCAN: begin
                if (i_stat.hit) begin
                    // Absorb the entry; if entries remain, fetch the last entry to fill its slot
                    ctrl.merge = 1'b1;
                    if (i_stat.scan_more) begin
                        ctrl.rd_en  = 1'b1;
                        ctrl.rd_sel = RSEL_LAST;
                    end
                end else if (i_stat.scan_more) begin
                    ctrl.rd_en   = 1'b1;
                    ctrl.rd_sel  = RSEL_NEXT;
                    ctrl.idx_inc = 1'b1;
                end
            end
            ST_MOVE: begin
                ctrl.wr_en  = 1'b1;
                ctrl.wr_sel = WSEL_IDX;
            end
            ST_APPEND: begin
                if (i_stat.count_full) begin
                    ctrl.set_ovf = 1'b1;
                end else begin
                    ctrl.wr_en   = 1'b1;
                    ctrl.wr_sel  = WSEL_CNT;
                    ctrl.cnt_inc = 1'b1;
                end
            end
            ST_DCHK: begin
                if (i_stat.tracking && i_stat.flushable && i_stat.seen
                    && i_stat.window_ok) begin
                    if (i_stat.ovf || i_stat.count_zero) begin
                        ctrl.out_fb = 1'b1;
                    end else begin
                        ctrl.rd_en    = 1'b1;
                        ctrl.rd_sel   = RSEL_ZERO;
                        ctrl.idx_zero = 1'b1;
                    end
                end
            end
            ST_DLOAD: begin
                ctrl.sub_sel = SUB_ENTRY;
                ctrl.out_rng = 1'b1;
            end
            ST_DOUT: begin
                if (i_stat.out_fire && !i_stat.out_last) begin
                    ctrl.rd_en   = 1'b1;
                    ctrl.rd_sel  = RSEL_NEXT;
                    ctrl.idx_inc = 1'b1;
                end
            end
            default: ctrl = '0;
        endcase
    end

    assign o_state = r_state;
    assign o_ctrl  = ctrl;

endmodule

/* rtl/dirty_range_coalescer.sv */
// Channel    Direction  Handshake                  Payload
// request    in         i_req_valid / o_req_ready  i_req_type, i_offset, i_length, i_whole_size
// range      out        o_rsp_valid / i_rsp_ready  o_range_offset, o_range_size, o_is_fallback,
//                                                  o_last
// config     in         i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// Record: accept, check, clip, then select; scan each entry, moving the tail entry into the slot of
// an absorbed one unless it was the last, then append. An ignored record or an empty clipped range
// returns to idle early; clear and unused codes finish in idle. Drain: accept and check, then load
// and output each range (no load for the whole window); the single table read port sets the pace.
// Reset is synchronous and active low; it empties the table and clears all flags.
// A stalled output holds the range and the sequencer until it is taken.
module dirty_range_coalescer import drc_pkg::*; #(
    parameter int MAX_RANGES = MAX_RANGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [39:0] i_cfg_data,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  logic [1:0]  i_req_type,
    input  logic [39:0] i_offset,
    input  logic [39:0] i_length,
    input  logic        i_whole_size,
    output logic        o_rsp_valid,
    input  logic        i_rsp_ready,
    output logic [39:0] o_range_offset,
    output logic [39:0] o_range_size,
    output logic        o_is_fallback,
    output logic        o_last
);

    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

    t_state state;
    t_ctrl  ctrl;
    t_stat  stat;

    // Configuration
    logic r_tracking;
    logic r_flushable;
    t_ofs r_map_start;
    t_ofs r_map_end;

    // Latched request
    t_ofs r_off;
    t_ofs r_len;
    logic r_whole;

    // Merge working range
    t_ofs        r_lo;
    t_ofs        r_hi;
    logic [40:0] r_diff;
    t_ofs        r_sum;

    // Table control
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_idx;
    logic          r_ovf;
    logic          r_seen;

    // Output register
    logic r_o_valid;
    t_ofs r_o_offset;
    t_ofs r_o_size;
    logic r_o_fb;
    logic r_o_last;

    // Table port signals
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    t_ofs               rd_start;
    t_ofs               rd_end;

    // Datapath
    t_ofs        sub_a;
    t_ofs        sub_b;
    logic [40:0] sub_res;
    logic        window_ok;
    t_ofs        lo_clip;
    logic        lo_lt_end;
    logic        use_sum;
    t_ofs        hi_sel;
    logic        clip_empty;
    logic        hit;
    logic [CW:0] idx_plus;
    logic        scan_more;
    logic        out_fire;

    drc_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_state (state),
        .o_ctrl  (ctrl)
    );

    drc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_RANGES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign rd_start = rd_data[ENTRY_W-1:OFS_W];
    assign rd_end   = rd_data[OFS_W-1:0];

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracking  <= 1'b0;
            r_map_start <= '0;
            r_map_end   <= '0;
            r_flushable <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TRACKING:  r_tracking  <= i_cfg_data[0];
                CFG_MAP_START: r_map_start <= i_cfg_data;
                CFG_MAP_END:   r_map_end   <= i_cfg_data;
                CFG_FLUSHABLE: r_flushable <= i_cfg_data[0];
            endcase
        end
    end

    // Shared subtractor: window size, room to window end, entry size
    always_comb begin
        unique case (ctrl.sub_sel)
            SUB_WINDOW: begin
                sub_a = r_map_end;
                sub_b = r_map_start;
            end
            SUB_CLIP: begin
                sub_a = r_map_end;
                sub_b = r_lo;
            end
            SUB_ENTRY: begin
                sub_a = rd_end;
                sub_b = rd_start;
            end
            default: begin
                sub_a = r_map_end;
                sub_b = r_map_start;
            end
        endcase
    end

    assign sub_res   = {1'b0, sub_a} - {1'b0, sub_b};
    assign window_ok = !sub_res[40] && (sub_res[39:0] != '0);

    // Clip the range to the window
    assign lo_clip    = (r_off > r_map_start) ? r_off : r_map_start;
    assign lo_lt_end  = !r_diff[40] && (r_diff[39:0] != '0);
    assign use_sum    = !r_whole && lo_lt_end && (r_len < r_diff[39:0]);
    assign hi_sel     = use_sum ? r_sum : r_map_end;
    assign clip_empty = use_sum ? (r_len == '0) : !lo_lt_end;

    // Overlap or touch test against the entry just read
    assign hit       = !((rd_end < r_lo) || (rd_start > r_hi));
    assign idx_plus  = (CW + 1)'(r_idx) + (CW + 1)'(1);
    assign scan_more = idx_plus < (CW + 1)'(r_count);
    assign out_fire  = r_o_valid && i_rsp_ready;

    // Latch request fields
    always_ff @(posedge i_clk) begin
        if (ctrl.take_req) begin
            r_off   <= i_offset;
            r_len   <= i_length;
            r_whole <= i_whole_size;
        end
    end

    // Working range
    always_ff @(posedge i_clk) begin
        if (ctrl.ld_lo) begin
            r_lo <= lo_clip;
        end else if (ctrl.merge) begin
            r_lo <= (rd_start < r_lo) ? rd_start : r_lo;
        end
        if (ctrl.ld_hi) begin
            r_hi <= hi_sel;
        end else if (ctrl.merge) begin
            r_hi <= (rd_end > r_hi) ? rd_end : r_hi;
        end
        if (ctrl.ld_clip) begin
            r_diff <= sub_res;
            r_sum  <= r_lo + r_len;
        end
    end

    // Table count, scan index and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
            r_ovf   <= 1'b0;
            r_seen  <= 1'b0;
        end else begin
            if (ctrl.do_clear) begin
                r_count <= '0;
            end else if (ctrl.merge) begin
                r_count <= r_count - CW'(1);
            end else if (ctrl.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end
            if (ctrl.idx_zero) begin
                r_idx <= '0;
            end else if (ctrl.idx_inc) begin
                r_idx <= r_idx + AW'(1);
            end
            if (ctrl.do_clear) begin
                r_ovf <= 1'b0;
            end else if (ctrl.set_ovf) begin
                r_ovf <= 1'b1;
            end
            if (ctrl.do_clear) begin
                r_seen <= 1'b0;
            end else if (ctrl.set_seen) begin
                r_seen <= 1'b1;
            end
        end
    end

    // Table addressing
    always_comb begin
        rd_en = ctrl.rd_en;
        unique case (ctrl.rd_sel)
            RSEL_ZERO: rd_addr = '0;
            RSEL_NEXT: rd_addr = r_idx + AW'(1);
            RSEL_LAST: rd_addr = AW'(r_count - CW'(1));
            default:   rd_addr = '0;
        endcase
        wr_en = ctrl.wr_en;
        unique case (ctrl.wr_sel)
            WSEL_IDX: begin
                wr_addr = r_idx;
                wr_data = rd_data;
            end
            WSEL_CNT: begin
                wr_addr = AW'(r_count);
                wr_data = {r_lo, r_hi};
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (ctrl.out_fb || ctrl.out_rng) begin
            r_o_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.out_fb) begin
            r_o_offset <= r_map_start;
            r_o_size   <= sub_res[39:0];
            r_o_fb     <= 1'b1;
            r_o_last   <= 1'b1;
        end else if (ctrl.out_rng) begin
            r_o_offset <= rd_start;
            r_o_size   <= sub_res[39:0];
            r_o_fb     <= 1'b0;
            r_o_last   <= !scan_more;
        end
    end

    // Status to the sequencer
    always_comb begin
        stat            = '0;
        stat.req_valid  = i_req_valid;
        stat.req_type   = i_req_type;
        stat.tracking   = r_tracking;
        stat.flushable  = r_flushable;
        stat.seen       = r_seen;
        stat.ovf        = r_ovf;
        stat.window_ok  = window_ok;
        stat.count_zero = (r_count == '0);
        stat.count_full = (r_count == CW'(MAX_RANGES));
        stat.clip_empty = clip_empty;
        stat.hit        = hit;
        stat.scan_more  = scan_more;
        stat.out_fire   = out_fire;
        stat.out_last   = r_o_last;
    end

    assign o_req_ready    = (state == ST_IDLE);
    assign o_rsp_valid    = r_o_valid;
    assign o_range_offset = r_o_offset;
    assign o_range_size   = r_o_size;
    assign o_is_fallback  = r_o_fb;
    assign o_last         = r_o_last;

    // Table never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_RANGES))
        else $error("interval count exceeds table depth");

    // A result is only offered while the drain waits on the output
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (state == ST_DOUT))
        else $error("output valid outside drain output state");

    // Once overflowed, the table stays frozen until cleared
    a_ovf_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovf && $past(r_ovf)) |-> (r_count == $past(r_count)))
        else $error("table changed after overflow");

endmodule

/* dv/tb_dirty_range_coalescer.sv */
module tb_dirty_range_coalescer;
    timeunit 1ns;
    timeprecision 1ps;

    import drc_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int   SETTLE_CYCLES = 60;
    localparam int   RANDOM_ITEMS  = 130;
    localparam t_ofs OFS_MAX       = '1;
    localparam t_ofs DIR_START     = 40'h100;
    localparam t_ofs DIR_STOP      = 40'h1100;

    // How a scripted request is checked
    localparam int EXP_PREDICT = -1;
    localparam int EXP_NONE    = 0;
    localparam int EXP_ONE     = 1;

    // Gap styles for either side
    localparam int GAP_RANDOM = 0;
    localparam int GAP_NONE   = 1;
    localparam int GAP_SHORT  = 2;

    typedef struct packed {
        logic [1:0] kind;
        t_ofs       ofs;
        t_ofs       len;
        logic       whole;
    } t_req;

    typedef struct packed {
        t_ofs ofs;
        t_ofs size;
        logic fb;
        logic lst;
    } t_rng;

    typedef struct {
        bit   reload;
        t_req req;
        int   typed;
        t_rng want;
    } t_step;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic [1:0]  i_cfg_index  = '0;
    logic [39:0] i_cfg_data   = '0;
    logic        i_req_valid  = 1'b0;
    logic        o_req_ready;
    logic [1:0]  i_req_type   = '0;
    logic [39:0] i_offset     = '0;
    logic [39:0] i_length     = '0;
    logic        i_whole_size = 1'b0;
    logic        o_rsp_valid;
    logic        i_rsp_ready  = 1'b0;
    logic [39:0] o_range_offset;
    logic [39:0] o_range_size;
    logic        o_is_fallback;
    logic        o_last;

    // Shadow of the registers and the interval table
    logic track_on = 1'b0;
    logic flush_ok = 1'b0;
    t_ofs win_lo   = '0;
    t_ofs win_hi   = '0;
    logic seen_wr  = 1'b0;
    logic tab_ovf  = 1'b0;
    int   tab_cnt  = 0;
    t_ofs tab_lo [MAX_RANGES_DEF];
    t_ofs tab_hi [MAX_RANGES_DEF];

    t_rng  ranges_due[$];
    t_rng  drain_buf[$];
    t_step script[$];

    int errors      = 0;
    int req_style   = GAP_RANDOM;
    int rsp_style   = GAP_RANDOM;

    dirty_range_coalescer u_top (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic t_ofs rand40();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[39:0];
    endfunction

    function automatic int pick_gap(input int style);
        case (style)
            GAP_NONE:  return 0;
            GAP_SHORT: return $urandom_range(0, 2);
            default:   return $urandom_range(0, 19);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input t_ofs got, input t_ofs want);
        errors++;
        $display("%0t: %s: got %h, want %h", $time, what, got, want);
    endtask

    // Apply one request to the shadow table; ranges a drain emits land in drain_buf
    function automatic void coalesce_request(input t_req r);
        t_ofs lo;
        t_ofs hi;
        int   i;
        drain_buf.delete();
        case (r.kind)
            REQ_RECORD: begin
                if (track_on) begin
                    seen_wr = 1'b1;
                    if (!tab_ovf && win_hi > win_lo) begin
                        // clip to the window
                        lo = (r.ofs > win_lo) ? r.ofs : win_lo;
                        hi = win_hi;
                        if (!r.whole && lo < hi && r.len < hi - lo) hi = lo + r.len;
                        if (lo < hi) begin
                            // single pass: absorb touching entries, refill slot from the tail
                            i = 0;
                            while (i < tab_cnt) begin
                                if (tab_hi[i] < lo || tab_lo[i] > hi) begin
                                    i++;
                                end else begin
                                    if (tab_lo[i] < lo) lo = tab_lo[i];
                                    if (tab_hi[i] > hi) hi = tab_hi[i];
                                    tab_cnt--;
                                    tab_lo[i] = tab_lo[tab_cnt];
                                    tab_hi[i] = tab_hi[tab_cnt];
                                end
                            end
                            if (tab_cnt >= MAX_RANGES_DEF) begin
                                tab_ovf = 1'b1;
                            end else begin
                                tab_lo[tab_cnt] = lo;
                                tab_hi[tab_cnt] = hi;
                                tab_cnt++;
                            end
                        end
                    end
                end
            end
            REQ_DRAIN: begin
                if (track_on && flush_ok && seen_wr && win_hi > win_lo) begin
                    if (tab_ovf || tab_cnt == 0) begin
                        drain_buf.push_back(t_rng'{win_lo, win_hi - win_lo, 1'b1, 1'b1});
                    end else begin
                        for (i = 0; i < tab_cnt; i++) begin
                            drain_buf.push_back(t_rng'{tab_lo[i], tab_hi[i] - tab_lo[i],
                                                       1'b0, i == tab_cnt - 1});
                        end
                    end
                end
            end
            REQ_CLEAR: begin
                tab_cnt = 0;
                tab_ovf = 1'b0;
                seen_wr = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // Present one request after a gap in the request style, hold it until taken, then predict
    task automatic issue_request(input t_req r, input int typed, input t_rng want);
        int gap;
        gap = pick_gap(req_style);
        @(negedge i_clk);
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req_valid  <= 1'b1;
        i_req_type   <= r.kind;
        i_offset     <= r.ofs;
        i_length     <= r.len;
        i_whole_size <= r.whole;
        do @(posedge i_clk); while (o_req_ready !== 1'b1);
        coalesce_request(r);
        case (typed)
            EXP_PREDICT: foreach (drain_buf[k]) ranges_due.push_back(drain_buf[k]);
            EXP_ONE:     ranges_due.push_back(want);
            default:     ;
        endcase
    endtask

    // Drop valid, let every due range drain, then give a record time to finish
    task automatic wait_quiet();
        @(negedge i_clk);
        i_req_valid <= 1'b0;
        while (ranges_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input t_ofs data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_TRACKING:  track_on = data[0];
            CFG_MAP_START: win_lo = data;
            CFG_MAP_END:   win_hi = data;
            default:       flush_ok = data[0];
        endcase
    endtask

    // Reprogram all four registers once the block is idle
    task automatic load_window(input logic en, input t_ofs ws, input t_ofs wstop,
                               input logic fl);
        t_ofs junk;
        wait_quiet();
        junk = rand40();
        junk[0] = en;
        write_reg(CFG_TRACKING, junk);
        write_reg(CFG_MAP_START, ws);
        write_reg(CFG_MAP_END, wstop);
        junk = rand40();
        junk[0] = fl;
        write_reg(CFG_FLUSHABLE, junk);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_step(input bit reload, input logic [1:0] kind, input t_ofs ofs,
                            input t_ofs len, input logic whole, input int typed,
                            input t_rng want);
        t_step s;
        s.reload = reload;
        s.req    = t_req'{kind, ofs, len, whole};
        s.typed  = typed;
        s.want   = want;
        script.push_back(s);
    endtask

    // Random request; records land on a grid over the window so they merge and fill
    function automatic t_req next_item(input bit fill);
        t_req r;
        t_ofs span;
        t_ofs unit;
        int   pick;
        int   grid_pos;
        pick    = $urandom_range(0, 99);
        r.kind  = 2'($urandom_range(0, 3));
        r.ofs   = rand40();
        r.len   = rand40();
        r.whole = 1'($urandom_range(0, 1));
        span = (win_hi > win_lo) ? win_hi - win_lo : t_ofs'(4096);
        unit = ((span >> 6) == 0) ? t_ofs'(1) : span >> 6;
        if (pick < 6) begin
            // noise: any code, any payload
        end else if (pick < 20) begin
            r.kind = REQ_DRAIN;
        end else if (pick < (fill ? 22 : 26)) begin
            r.kind = REQ_CLEAR;
        end else begin
            r.kind = REQ_RECORD;
            if (fill) begin
                grid_pos = 2 * $urandom_range(0, 31);
                r.len    = unit;
                r.whole  = 1'b0;
            end else begin
                grid_pos = $urandom_range(0, 63);
                r.len    = unit * t_ofs'($urandom_range(0, 2)) + t_ofs'($urandom_range(0, 3));
                r.whole  = ($urandom_range(0, 15) == 0);
            end
            r.ofs = win_lo + unit * t_ofs'(grid_pos);
            if ($urandom_range(0, 9) == 0) r.ofs = win_lo - t_ofs'($urandom_range(1, 4096));
        end
        return r;
    endfunction

    // Check each taken range against the oldest one due
    initial begin : take_ranges
        int   stall;
        t_rng w;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = pick_gap(rsp_style);
            @(negedge i_clk);
            if (stall > 0) begin
                i_rsp_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_rsp_ready <= 1'b1;
            do @(posedge i_clk); while (o_rsp_valid !== 1'b1);
            if (ranges_due.size() == 0) begin
                report_mismatch("range with none due", o_range_offset, '0);
            end else begin
                w = ranges_due.pop_front();
                if (o_range_offset !== w.ofs)
                    report_mismatch("range_offset", o_range_offset, w.ofs);
                if (o_range_size !== w.size)
                    report_mismatch("range_size", o_range_size, w.size);
                if (o_is_fallback !== w.fb)
                    report_mismatch("is_fallback", t_ofs'(o_is_fallback), t_ofs'(w.fb));
                if (o_last !== w.lst)
                    report_mismatch("last", t_ofs'(o_last), t_ofs'(w.lst));
            end
        end
    end

    initial begin : run
        t_req r;
        int   p;
        int   counted;
        int   n_items;
        bit   fill;
        t_ofs ws;

        // Hold reset
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Tracking off after reset: nothing drained, record ignored
        add_step(0, REQ_DRAIN, '0, '0, 1'b0, EXP_NONE, '0);
        add_step(0, REQ_RECORD, 'h100, 'h10, 1'b0, EXP_NONE, '0);
        // Window open but no write seen yet
        add_step(1, REQ_DRAIN, '0, '0, 1'b0, EXP_NONE, '0);
        add_step(0, REQ_RECORD, 'h200, 'h100, 1'b0, EXP_PREDICT, '0);
        add_step(0, REQ_DRAIN, '0, '0, 1'b0, EXP_ONE, t_rng'{40'h200, 40'h100, 1'b0, 1'b1});
        // Touching range, range starting below the window, whole size
        add_step(0, REQ_RECORD, 'h300, 'h80, 1'b0, EXP_PREDICT, '0);
        add_step(0, REQ_RECORD, 'h0, 'h180, 1'b0, EXP_PREDICT, '0);
        add_step(0, REQ_RECORD, 'h800, 'h5, 1'b1, EXP_PREDICT, '0);
        // Empty after clipping: at the window end, zero length, far beyond
        add_step(0, REQ_RECORD, 'h1100, 'h5, 1'b0, EXP_PREDICT, '0);
        add_step(0, REQ_RECORD, 'h600, '0, 1'b0, EXP_PREDICT, '0);
        add_step(0, REQ_RECORD, OFS_MAX, OFS_MAX, 1'b1, EXP_PREDICT, '0);
        // Bridge two entries so the tail entry is moved in and absorbed too
        add_step(0, REQ_RECORD, 'h500, 'h10, 1'b0, EXP_PREDICT, '0);
        add_step(0, REQ_RECORD, 'h380, 'h180, 1'b0, EXP_PREDICT, '0);
        add_step(0, REQ_DRAIN, OFS_MAX, OFS_MAX, 1'b1, EXP_PREDICT, '0);
        // Unused code, clear, drain after clear
        add_step(0, REQ_UNUSED, OFS_MAX, OFS_MAX, 1'b1, EXP_NONE, '0);
        add_step(0, REQ_CLEAR, '0, '0, 1'b0, EXP_NONE, '0);
        add_step(0, REQ_DRAIN, '0, '0, 1'b0, EXP_NONE, '0);
        // Write seen but table empty: whole window as fallback
        add_step(0, REQ_RECORD, '0, '0, 1'b0, EXP_NONE, '0);
        add_step(0, REQ_DRAIN, '0, '0, 1'b0, EXP_ONE,
                 t_rng'{DIR_START, DIR_STOP - DIR_START, 1'b1, 1'b1});
        // Huge length clips to the window end
        add_step(0, REQ_RECORD, 'h100, OFS_MAX, 1'b0, EXP_NONE, '0);
        add_step(0, REQ_DRAIN, '0, '0, 1'b0, EXP_ONE,
                 t_rng'{DIR_START, DIR_STOP - DIR_START, 1'b0, 1'b1});

        foreach (script[k]) begin
            if (script[k].reload) load_window(1'b1, DIR_START, DIR_STOP, 1'b1);
            issue_request(script[k].req, script[k].typed, script[k].want);
        end

        // Random phases, each under its own window setting
        p = 0;
        counted = 0;
        while (counted < RANDOM_ITEMS && p < 32) begin
            req_style = $urandom_range(GAP_RANDOM, GAP_SHORT);
            rsp_style = $urandom_range(GAP_RANDOM, GAP_SHORT);
            fill = (p % 3 == 1);
            case (p % 8)
                0: load_window(1'b1, '0, OFS_MAX, 1'b1);
                1: begin
                    ws = t_ofs'($urandom) << 7;
                    load_window(1'b1, ws, ws + t_ofs'($urandom_range(64, 65536)), 1'b1);
                end
                2: load_window(1'($urandom_range(0, 1)), rand40(), rand40(),
                               1'($urandom_range(0, 1)));
                3: begin
                    ws = rand40();
                    load_window(1'b1, ws, ws, 1'b1);
                end
                4: load_window(1'b0, 40'h1000, 40'h9000, 1'b1);
                5: load_window(1'b1, 40'h1000, 40'h9000, 1'b0);
                6: load_window(1'b1, OFS_MAX - 40'd4095, OFS_MAX, 1'b1);
                default: load_window(1'b1, 40'd1, 40'd65, 1'b1);
            endcase
            n_items = fill ? $urandom_range(24, 36) : $urandom_range(12, 28);
            repeat (n_items) begin
                r = next_item(fill);
                counted++;
                issue_request(r, EXP_PREDICT, '0);
            end
            p++;
        end

        wait_quiet();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
